FILE: design/box_surface_point_sampler_assert.svh
// assertion macros for the box surface point sampler
// used by box_surface_point_sampler.sv, needs i_clk and i_rst_n in scope
`ifndef BOX_SURFACE_POINT_SAMPLER_ASSERT_SVH
`define BOX_SURFACE_POINT_SAMPLER_ASSERT_SVH
`ifndef SYNTH
`define BSPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bsps assertion failed");
`define BSPS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("bsps assertion failed");
`else
`define BSPS_ASSERT(lbl, prop)
`define BSPS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: design/bsps_pkg.sv
// shared types and constants of the box surface point sampler
// no dependencies
`default_nettype none
package bsps_pkg;
    localparam int COORD_W    = 32;
    localparam int FACE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int Q_W        = 32;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = Q_W / DIV_BITS;
    localparam logic [COORD_W-1:0] MAX_RESET = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg;

    typedef enum logic [FACE_W-1:0] {
        FACE_NX = 3'd0,
        FACE_PX = 3'd1,
        FACE_NY = 3'd2,
        FACE_PY = 3'd3,
        FACE_NZ = 3'd4,
        FACE_PZ = 3'd5
    } t_face;

    typedef enum logic [1:0] {
        FM_NORMAL = 2'd0,
        FM_ZERO   = 2'd1,
        FM_SAT    = 2'd2
    } t_frac_mode;

    typedef struct packed {
        logic       valid;
        t_face      face;
        t_frac_mode mode;
    } t_div_ctl;
endpackage
`default_nettype wire

FILE: design/bsps_sample_if.sv
// request channel carrying the two sample fractions
// depends on nothing
`default_nettype none
interface bsps_sample_if #(parameter int SAMPLE_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_u;
    logic [SAMPLE_BITS-1:0] sample_v;
    modport source (output valid, output sample_u, output sample_v, input ready);
    modport sink (input valid, input sample_u, input sample_v, output ready);
endinterface
`default_nettype wire

FILE: design/bsps_point_if.sv
// result channel carrying the sampled point and face code
// depends on nothing
`default_nettype none
interface bsps_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [2:0]         face_code;
    modport source (output valid, output point_x, output point_y, output point_z,
                    output face_code, input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  input face_code, output ready);
endinterface
`default_nettype wire

FILE: design/bsps_div_stage.sv
// one registered stage of the in-face fraction divider, two quotient bits
// depends on bsps_pkg
`default_nettype none
module bsps_div_stage #(
    parameter int AREA_W   = 48,
    parameter int SAMPLE_W = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire bsps_pkg::t_div_ctl        i_ctl,
    input  wire logic [AREA_W-1:0]         i_r,
    input  wire logic [AREA_W-1:0]         i_area,
    input  wire logic [bsps_pkg::Q_W-1:0]  i_q,
    input  wire logic [SAMPLE_W-1:0]       i_sv,
    output bsps_pkg::t_div_ctl             o_ctl,
    output logic [AREA_W-1:0]              o_r,
    output logic [AREA_W-1:0]              o_area,
    output logic [bsps_pkg::Q_W-1:0]       o_q,
    output logic [SAMPLE_W-1:0]            o_sv
);
    bsps_pkg::t_div_ctl          r_ctl;
    logic [AREA_W-1:0]           r_r;
    logic [AREA_W-1:0]           r_area;
    logic [bsps_pkg::Q_W-1:0]    r_q;
    logic [SAMPLE_W-1:0]         r_sv;
    logic [AREA_W-1:0]           n_r;
    logic [bsps_pkg::Q_W-1:0]    n_q;

    always_comb begin
        logic [AREA_W:0] w_t;
        logic [AREA_W:0] w_d;
        n_r = i_r;
        n_q = i_q;
        for (int j = 0; j < bsps_pkg::DIV_BITS; j++) begin
            w_t = {n_r, 1'b0};
            w_d = w_t - {1'b0, i_area};
            if (w_t >= {1'b0, i_area}) begin
                n_r = w_d[AREA_W-1:0];
                n_q = {n_q[bsps_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_r = w_t[AREA_W-1:0];
                n_q = {n_q[bsps_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_r    <= n_r;
            r_q    <= n_q;
            r_area <= i_area;
            r_sv   <= i_sv;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_r    = r_r;
    assign o_area = r_area;
    assign o_q    = r_q;
    assign o_sv   = r_sv;
endmodule
`default_nettype wire

FILE: design/box_surface_point_sampler.sv
// top level of the box surface point sampler
// depends on bsps_pkg, bsps_sample_if, bsps_point_if, bsps_div_stage and the assert header
`default_nettype none
// Takes one request per clock while the output is not held and returns one point per request, in order.
// Its stages: seven front stages (sample align, two product halves of the
// scaled sample, face pick, remainder), sixteen divider stages of two
// quotient bits each, one multiply stage for the edge offsets and the
// output register. Every stage has its own valid bit and holds only while
// the stages after it are full, so bubbles close up and a request is taken
// whenever any stage is free.
// Extents, face areas and their running sums are registered in turn from the box
// registers and settle after a write; the front stages cover that.
module box_surface_point_sampler #(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bsps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bsps_pkg::COORD_W-1:0]      i_cfg_data,
    bsps_sample_if.sink                            i_smp,
    bsps_point_if.source                           o_pt
);
    localparam int CW  = bsps_pkg::COORD_W;
    localparam int AW  = 2 * CW - FRAC_BITS;
    localparam int TW  = AW + 3;
    localparam int HW  = TW / 2;
    localparam int SW  = SAMPLE_BITS;
    localparam int PHW = TW - HW + SW;
    localparam int PLW = HW + SW;
    localparam int ND  = bsps_pkg::DIV_STAGES;
    localparam int QW  = bsps_pkg::Q_W;

    function automatic logic [CW-1:0] extent(input logic [CW-1:0] lo,
                                             input logic [CW-1:0] hi);
        logic [CW:0] d;
        d = {hi[CW-1], hi} - {lo[CW-1], lo};
        return d[CW] ? '0 : d[CW-1:0];
    endfunction

    // box registers
    logic signed [CW-1:0] r_min_x, r_min_y, r_min_z, r_max_x, r_max_y, r_max_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_min_z <= '0;
            r_max_x <= bsps_pkg::MAX_RESET;
            r_max_y <= bsps_pkg::MAX_RESET;
            r_max_z <= bsps_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (bsps_pkg::t_reg'(i_cfg_idx))
                bsps_pkg::REG_MIN_X: r_min_x <= i_cfg_data;
                bsps_pkg::REG_MIN_Y: r_min_y <= i_cfg_data;
                bsps_pkg::REG_MIN_Z: r_min_z <= i_cfg_data;
                bsps_pkg::REG_MAX_X: r_max_x <= i_cfg_data;
                bsps_pkg::REG_MAX_Y: r_max_y <= i_cfg_data;
                bsps_pkg::REG_MAX_Z: r_max_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived box values
    logic [CW-1:0]   r_dx, r_dy, r_dz;
    logic [AW-1:0]   r_ax, r_ay, r_az;
    logic [TW-1:0]   r_c1, r_c2, r_c3, r_c4, r_c5, r_tot;
    logic [2*CW-1:0] w_pyz, w_pxz, w_pxy;
    logic [TW-1:0]   w_ax_e, w_ay_e, w_az_e;

    assign w_pyz  = r_dy * r_dz;
    assign w_pxz  = r_dx * r_dz;
    assign w_pxy  = r_dx * r_dy;
    assign w_ax_e = TW'(r_ax);
    assign w_ay_e = TW'(r_ay);
    assign w_az_e = TW'(r_az);

    always_ff @(posedge i_clk) begin
        r_dx  <= extent(r_min_x, r_max_x);
        r_dy  <= extent(r_min_y, r_max_y);
        r_dz  <= extent(r_min_z, r_max_z);
        r_ax  <= w_pyz[2*CW-1:FRAC_BITS];
        r_ay  <= w_pxz[2*CW-1:FRAC_BITS];
        r_az  <= w_pxy[2*CW-1:FRAC_BITS];
        r_c1  <= w_ax_e;
        r_c2  <= w_ax_e << 1;
        r_c3  <= (w_ax_e << 1) + w_ay_e;
        r_c4  <= (w_ax_e + w_ay_e) << 1;
        r_c5  <= ((w_ax_e + w_ay_e) << 1) + w_az_e;
        r_tot <= (w_ax_e + w_ay_e + w_az_e) << 1;
    end

    // stage advance chain
    logic w_adv0, w_adv1, w_adv2, w_adv3, w_adv4, w_adv5, w_adv6, w_adv_m, w_adv_p;
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_vm, r_vp;
    logic [ND-1:0] w_dadv;

    bsps_pkg::t_div_ctl w_dctl [ND+1];
    logic [AW-1:0]      w_dr   [ND+1];
    logic [AW-1:0]      w_darea[ND+1];
    logic [QW-1:0]      w_dq   [ND+1];
    logic [SW-1:0]      w_dsv  [ND+1];

    assign w_adv_p = !r_vp || o_pt.ready;
    assign w_adv_m = !r_vm || w_adv_p;
    assign w_adv6  = !r_v6 || w_dadv[0];
    assign w_adv5  = !r_v5 || w_adv6;
    assign w_adv4  = !r_v4 || w_adv5;
    assign w_adv3  = !r_v3 || w_adv4;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign w_adv0  = !r_v0 || w_adv1;
    assign i_smp.ready = w_adv0;

    // front stages
    logic [SW-1:0]  r_su0, r_su1, r_su2;
    logic [SW-1:0]  r_sv0, r_sv1, r_sv2, r_sv3, r_sv4, r_sv5, r_sv6;
    logic [PHW-1:0] r_phi;
    logic [PLW-1:0] r_plo;
    logic [TW-1:0]  r_u4, r_u5, r_base5;
    logic [AW-1:0]  r_area5, r_area6, r_r6;
    bsps_pkg::t_face      r_face5, r_face6;
    bsps_pkg::t_frac_mode r_mode6;
    logic [TW+SW-1:0] w_usum;
    bsps_pkg::t_face      n_face;
    logic [TW-1:0]        n_base;
    logic [AW-1:0]        n_area;
    logic [TW-1:0]        w_rem;
    bsps_pkg::t_frac_mode n_mode;

    assign w_usum = {r_phi, {HW{1'b0}}} + (TW + SW)'(r_plo);

    always_comb begin
        priority if (r_u4 < r_c1) begin
            n_face = bsps_pkg::FACE_NX; n_base = '0;   n_area = r_ax;
        end else if (r_u4 < r_c2) begin
            n_face = bsps_pkg::FACE_PX; n_base = r_c1; n_area = r_ax;
        end else if (r_u4 < r_c3) begin
            n_face = bsps_pkg::FACE_NY; n_base = r_c2; n_area = r_ay;
        end else if (r_u4 < r_c4) begin
            n_face = bsps_pkg::FACE_PY; n_base = r_c3; n_area = r_ay;
        end else if (r_u4 < r_c5) begin
            n_face = bsps_pkg::FACE_NZ; n_base = r_c4; n_area = r_az;
        end else begin
            n_face = bsps_pkg::FACE_PZ; n_base = r_c5; n_area = r_az;
        end
    end

    assign w_rem = r_u5 - r_base5;

    always_comb begin
        priority if (r_area5 == '0) begin
            n_mode = bsps_pkg::FM_ZERO;
        end else if (w_rem >= TW'(r_area5)) begin
            n_mode = bsps_pkg::FM_SAT;
        end else begin
            n_mode = bsps_pkg::FM_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_adv0) r_v0 <= i_smp.valid;
            if (w_adv1) r_v1 <= r_v0;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
            if (w_adv5) r_v5 <= r_v4;
            if (w_adv6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv0) begin
            r_su0 <= i_smp.sample_u;
            r_sv0 <= i_smp.sample_v;
        end
        if (w_adv1) begin
            r_su1 <= r_su0;
            r_sv1 <= r_sv0;
        end
        if (w_adv2) begin
            r_su2 <= r_su1;
            r_sv2 <= r_sv1;
        end
        if (w_adv3) begin
            r_phi <= r_tot[TW-1:HW] * r_su2;
            r_plo <= r_tot[HW-1:0] * r_su2;
            r_sv3 <= r_sv2;
        end
        if (w_adv4) begin
            r_u4  <= w_usum[TW+SW-1:SW];
            r_sv4 <= r_sv3;
        end
        if (w_adv5) begin
            r_u5    <= r_u4;
            r_face5 <= n_face;
            r_base5 <= n_base;
            r_area5 <= n_area;
            r_sv5   <= r_sv4;
        end
        if (w_adv6) begin
            r_face6 <= r_face5;
            r_mode6 <= n_mode;
            r_area6 <= r_area5;
            r_r6    <= (n_mode == bsps_pkg::FM_NORMAL) ? w_rem[AW-1:0] : '0;
            r_sv6   <= r_sv5;
        end
    end

    // divider
    assign w_dctl[0]  = '{valid: r_v6, face: r_face6, mode: r_mode6};
    assign w_dr[0]    = r_r6;
    assign w_darea[0] = r_area6;
    assign w_dq[0]    = '0;
    assign w_dsv[0]   = r_sv6;

    for (genvar k = 0; k < ND; k++) begin : g_div
        if (k == ND - 1) begin : g_last
            assign w_dadv[k] = !w_dctl[k+1].valid || w_adv_m;
        end else begin : g_mid
            assign w_dadv[k] = !w_dctl[k+1].valid || w_dadv[k+1];
        end
        bsps_div_stage #(
            .AREA_W   (AW),
            .SAMPLE_W (SW)
        ) u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_dadv[k]),
            .i_ctl  (w_dctl[k]),
            .i_r    (w_dr[k]),
            .i_area (w_darea[k]),
            .i_q    (w_dq[k]),
            .i_sv   (w_dsv[k]),
            .o_ctl  (w_dctl[k+1]),
            .o_r    (w_dr[k+1]),
            .o_area (w_darea[k+1]),
            .o_q    (w_dq[k+1]),
            .o_sv   (w_dsv[k+1])
        );
    end

    // edge offsets
    logic [QW-1:0]      w_f;
    logic [CW-1:0]      w_ea, w_eb;
    logic [QW+CW-1:0]   w_pa;
    logic [SW+CW-1:0]   w_pb;
    logic [CW-1:0]      r_off1, r_off2;
    bsps_pkg::t_face    r_face_m;
    bsps_pkg::t_div_ctl w_last;

    assign w_last = w_dctl[ND];

    always_comb begin
        unique case (w_last.mode)
            bsps_pkg::FM_NORMAL: w_f = w_dq[ND];
            bsps_pkg::FM_SAT:    w_f = '1;
            default:             w_f = '0;
        endcase
        unique case (w_last.face)
            bsps_pkg::FACE_NX, bsps_pkg::FACE_PX: begin
                w_ea = r_dy; w_eb = r_dz;
            end
            bsps_pkg::FACE_NY, bsps_pkg::FACE_PY: begin
                w_ea = r_dx; w_eb = r_dz;
            end
            default: begin
                w_ea = r_dx; w_eb = r_dy;
            end
        endcase
    end

    assign w_pa = w_f * w_ea;
    assign w_pb = w_dsv[ND] * w_eb;

    always_ff @(posedge i_clk) begin
        if (w_adv_m) begin
            r_off1   <= w_pa[QW+CW-1:QW];
            r_off2   <= w_pb[SW+CW-1:SW];
            r_face_m <= w_last.face;
        end
    end

    // output register
    logic signed [CW-1:0] r_px, r_py, r_pz, n_px, n_py, n_pz;
    bsps_pkg::t_face      r_face_p;

    always_comb begin
        unique case (r_face_m)
            bsps_pkg::FACE_NX, bsps_pkg::FACE_PX: begin
                n_px = (r_face_m == bsps_pkg::FACE_NX) ? r_min_x : r_max_x;
                n_py = r_min_y + r_off1;
                n_pz = r_min_z + r_off2;
            end
            bsps_pkg::FACE_NY, bsps_pkg::FACE_PY: begin
                n_px = r_min_x + r_off1;
                n_py = (r_face_m == bsps_pkg::FACE_NY) ? r_min_y : r_max_y;
                n_pz = r_min_z + r_off2;
            end
            default: begin
                n_px = r_min_x + r_off1;
                n_py = r_min_y + r_off2;
                n_pz = (r_face_m == bsps_pkg::FACE_NZ) ? r_min_z : r_max_z;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vp <= 1'b0;
        end else begin
            if (w_adv_m) r_vm <= w_last.valid;
            if (w_adv_p) r_vp <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_p) begin
            r_px     <= n_px;
            r_py     <= n_py;
            r_pz     <= n_pz;
            r_face_p <= r_face_m;
        end
    end

    assign o_pt.valid     = r_vp;
    assign o_pt.point_x   = r_px;
    assign o_pt.point_y   = r_py;
    assign o_pt.point_z   = r_pz;
    assign o_pt.face_code = r_face_p;

`include "box_surface_point_sampler_assert.svh"

    `BSPS_ASSERT(a_u_not_below_base, r_v5 |-> r_u5 >= r_base5)
    `BSPS_ASSERT(a_normal_needs_area, r_v6 && r_mode6 == bsps_pkg::FM_NORMAL |-> r_area6 != '0)
    `BSPS_ASSERT_ALWAYS(a_in_stall_from_out, !i_smp.ready |-> o_pt.valid && !o_pt.ready)
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// self-checking testbench for box_surface_point_sampler: random and directed samples
// over several box settings, checked against an in-bench predictor of the point and face
// depends on bsps_pkg, bsps_sample_if, bsps_point_if and the block itself
`default_nettype none
module tb_top;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [2:0]  face;
    } t_point;

    class point_scoreboard;
        logic [31:0] box[6];
        t_point      pending[$];
        int          errors;
        int          checked;

        function new();
            box[bsps_pkg::REG_MIN_X] = 0;
            box[bsps_pkg::REG_MIN_Y] = 0;
            box[bsps_pkg::REG_MIN_Z] = 0;
            box[bsps_pkg::REG_MAX_X] = bsps_pkg::MAX_RESET;
            box[bsps_pkg::REG_MAX_Y] = bsps_pkg::MAX_RESET;
            box[bsps_pkg::REG_MAX_Z] = bsps_pkg::MAX_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function longint unsigned span(logic [31:0] lo, logic [31:0] hi);
            longint d;
            d = longint'($signed(hi)) - longint'($signed(lo));
            return d < 0 ? 0 : longint'(d);
        endfunction

        function longint unsigned in_face_frac(longint unsigned rem, longint unsigned area);
            longint unsigned q;
            q = 0;
            if (area == 0) return 0;
            if (rem >= area) return 64'hFFFF_FFFF;
            for (int i = 0; i < 32; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= area) begin
                    rem = rem - area;
                    q   = q | 1;
                end
            end
            return q;
        endfunction

        function void note_request(logic [15:0] su, logic [15:0] sv);
            longint unsigned dx, dy, dz, ax, ay, az, total, uu, area, f;
            longint unsigned su_w, sv_w;
            bsps_pkg::t_face fc;
            t_point          e;
            su_w  = su;
            sv_w  = sv;
            dx    = span(box[bsps_pkg::REG_MIN_X], box[bsps_pkg::REG_MAX_X]);
            dy    = span(box[bsps_pkg::REG_MIN_Y], box[bsps_pkg::REG_MAX_Y]);
            dz    = span(box[bsps_pkg::REG_MIN_Z], box[bsps_pkg::REG_MAX_Z]);
            ax    = (dy * dz) >> 16;
            ay    = (dx * dz) >> 16;
            az    = (dx * dy) >> 16;
            total = 2 * (ax + ay + az);
            uu    = (total >> 16) * su_w + (((total & 64'hFFFF) * su_w) >> 16);
            if (uu < ax) begin
                fc = bsps_pkg::FACE_NX; area = ax;
            end else if ((uu - ax) < ax) begin
                uu = uu - ax; fc = bsps_pkg::FACE_PX; area = ax;
            end else if ((uu - 2 * ax) < ay) begin
                uu = uu - 2 * ax; fc = bsps_pkg::FACE_NY; area = ay;
            end else if ((uu - 2 * ax - ay) < ay) begin
                uu = uu - 2 * ax - ay; fc = bsps_pkg::FACE_PY; area = ay;
            end else if ((uu - 2 * ax - 2 * ay) < az) begin
                uu = uu - 2 * ax - 2 * ay; fc = bsps_pkg::FACE_NZ; area = az;
            end else begin
                uu = uu - 2 * ax - 2 * ay - az; fc = bsps_pkg::FACE_PZ; area = az;
            end
            f = in_face_frac(uu, area);
            if (fc == bsps_pkg::FACE_NX || fc == bsps_pkg::FACE_PX) begin
                e.px = (fc == bsps_pkg::FACE_NX) ? box[bsps_pkg::REG_MIN_X]
                                                 : box[bsps_pkg::REG_MAX_X];
                e.py = box[bsps_pkg::REG_MIN_Y] + 32'((f * dy) >> 32);
                e.pz = box[bsps_pkg::REG_MIN_Z] + 32'((sv_w * dz) >> 16);
            end else if (fc == bsps_pkg::FACE_NY || fc == bsps_pkg::FACE_PY) begin
                e.px = box[bsps_pkg::REG_MIN_X] + 32'((f * dx) >> 32);
                e.py = (fc == bsps_pkg::FACE_NY) ? box[bsps_pkg::REG_MIN_Y]
                                                 : box[bsps_pkg::REG_MAX_Y];
                e.pz = box[bsps_pkg::REG_MIN_Z] + 32'((sv_w * dz) >> 16);
            end else begin
                e.px = box[bsps_pkg::REG_MIN_X] + 32'((f * dx) >> 32);
                e.py = box[bsps_pkg::REG_MIN_Y] + 32'((sv_w * dy) >> 16);
                e.pz = (fc == bsps_pkg::FACE_NZ) ? box[bsps_pkg::REG_MIN_Z]
                                                 : box[bsps_pkg::REG_MAX_Z];
            end
            e.face = fc;
            pending = {pending, e};
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic [2:0] face);
            t_point e;
            if (pending.size() == 0) begin
                report("unexpected point", px, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (px != e.px) report("point_x", px, e.px);
            if (py != e.py) report("point_y", py, e.py);
            if (pz != e.pz) report("point_z", pz, e.pz);
            if (face != e.face) report("face_code", face, e.face);
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [bsps_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [bsps_pkg::COORD_W-1:0]   cfg_data;
    int                             hold_cycles;
    bit                             quiet;
    int                             sent;
    point_scoreboard                sb;

    bsps_sample_if #(.SAMPLE_BITS(16)) smp();
    bsps_point_if                      pt();

    box_surface_point_sampler i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_smp     (smp),
        .o_pt      (pt)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // accepted requests and results, sampled before the edge updates anything
    always @(posedge i_clk) begin
        if (i_rst_n && smp.valid && smp.ready) sb.note_request(smp.sample_u, smp.sample_v);
        if (i_rst_n && pt.valid && pt.ready)
            sb.check_point(pt.point_x, pt.point_y, pt.point_z, pt.face_code);
    end

    // receiver with random stalls and an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            pt.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            pt.ready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    task send_sample(logic [15:0] su, logic [15:0] sv);
        while (!quiet && $urandom_range(99) < 13) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid    <= 1'b1;
        smp.sample_u <= su;
        smp.sample_v <= sv;
        do @(posedge i_clk); while (!smp.ready);
        sent++;
    endtask

    task drain();
        int n;
        n = 0;
        smp.valid <= 1'b0;
        while (sb.pending.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (30) @(posedge i_clk);
    endtask

    task load_box(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                  logic [31:0] v3, logic [31:0] v4, logic [31:0] v5);
        logic [31:0] v[6];
        v = '{v0, v1, v2, v3, v4, v5};
        for (int i = 0; i < 6; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= bsps_pkg::CFG_IDX_W'(i);
            cfg_data <= v[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        for (int i = 0; i < 6; i++) sb.box[i] = v[i];
    endtask

    task random_samples(int n);
        logic [15:0] su, sv;
        for (int i = 0; i < n; i++) begin
            su = 16'($urandom());
            sv = 16'($urandom());
            case ($urandom_range(9))
                0: su = 16'h0000;
                1: su = 16'hFFFF;
                2: sv = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
                default: ;
            endcase
            send_sample(su, sv);
        end
    endtask

    initial begin
        logic [31:0] lo, ext;
        logic [15:0] edges[18];
        sb           = new();
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        smp.valid    = 1'b0;
        smp.sample_u = '0;
        smp.sample_v = '0;
        pt.ready     = 1'b0;
        hold_cycles  = 0;
        quiet        = 1'b0;
        sent         = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit cube after reset: face boundaries sit near multiples of 65536/6
        edges = '{16'd0, 16'd1, 16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767,
                  16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614, 16'h5555,
                  16'hAAAA, 16'hFFFE, 16'hFFFF, 16'h8000, 16'h7FFF};
        foreach (edges[i]) send_sample(edges[i], (i % 2) ? 16'hFFFF : 16'h0000);
        random_samples(130);
        drain();

        // widest box with no idling
        quiet = 1'b1;
        load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        random_samples(150);
        drain();
        quiet = 1'b0;

        // inverted x extent
        load_box(32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000,
                 32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
        random_samples(150);
        drain();

        // flat in z, receiver holds off while requests keep coming
        load_box(32'hFFF0_0000, 32'h0000_1234, 32'h0005_0000,
                 32'h0010_0000, 32'h0020_0000, 32'h0005_0000);
        hold_cycles = 300;
        random_samples(150);
        drain();

        // every extent zero
        load_box(32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF,
                 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'hFFFF, 16'h0000);
        random_samples(100);
        drain();

        // small negative box, with a pause until all points are back
        load_box(32'hFFFF_FF00, 32'hFFFF_FE00, 32'hFFFF_FFF0,
                 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);
        random_samples(70);
        drain();
        random_samples(80);
        drain();

        for (int p = 0; p < 5; p++) begin
            lo  = $urandom();
            ext = (p % 2) ? $urandom() : $urandom_range(32'h0100_0000);
            load_box(lo, $urandom(), lo - 32'h100, lo + ext,
                     $urandom(), lo + (ext >> 3));
            random_samples(130);
            drain();
        end

        $display("%0d samples sent over eleven box settings, %0d points checked",
                 sent, sb.checked);
        $display("boxes covered: reset cube, widest range, inverted, flat, empty, random");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
